FILE: rtl/core/csp_pkg.sv
// Shared types and constants for the CIGAR string parser.
// Depends on nothing; imported by every module of the block.
package csp_pkg;

    // Record status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EMPTY      = 3'd1;
    localparam logic [2:0] ST_BAD_FORMAT = 3'd2;
    localparam logic [2:0] ST_BAD_OP     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;

    // Operation codes
    localparam logic [3:0] OP_M    = 4'd0;
    localparam logic [3:0] OP_I    = 4'd1;
    localparam logic [3:0] OP_D    = 4'd2;
    localparam logic [3:0] OP_N    = 4'd3;
    localparam logic [3:0] OP_S    = 4'd4;
    localparam logic [3:0] OP_H    = 4'd5;
    localparam logic [3:0] OP_P    = 4'd6;
    localparam logic [3:0] OP_EQ   = 4'd7;
    localparam logic [3:0] OP_X    = 4'd8;
    localparam logic [3:0] OP_NONE = 4'd15;

    // Result kinds
    localparam logic KIND_OP     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Characters
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [3:0]  op_code;
        logic [31:0] op_length;
        logic [2:0]  status;
        logic        eor;
    } result_t;

    // Results produced by one accepted character, in delivery order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [3:0] op_of(input logic [7:0] c);
        logic [3:0] code;
        case (c)
            8'h4D:   code = OP_M;
            8'h49:   code = OP_I;
            8'h44:   code = OP_D;
            8'h4E:   code = OP_N;
            8'h53:   code = OP_S;
            8'h48:   code = OP_H;
            8'h50:   code = OP_P;
            8'h3D:   code = OP_EQ;
            8'h58:   code = OP_X;
            default: code = OP_NONE;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/core/csp_parser.sv
// Per-character parse step: length accumulation, op decode, error latch.
// Depends on csp_pkg.
module csp_parser
    import csp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] ch,
    input  logic       record_empty,
    input  logic       last_char,
    output push_t      push
);

    logic                     at_start_reg, at_start_next;
    logic                     have_digits_reg, have_digits_next;
    logic [LENGTH_BITS-1:0]   acc_reg, acc_next;
    logic                     ovf_reg, ovf_next;
    logic [2:0]               err_reg, err_next;

    logic [LENGTH_BITS+3:0]   prod;
    logic [LENGTH_BITS+31:0]  acc_wide;
    logic [3:0]               code;
    logic                     is_digit;
    logic                     op_valid;
    logic                     st_valid;
    logic [2:0]               st_val;
    result_t                  op_res;
    result_t                  st_res;

    // acc * 10 + digit; any bit above LENGTH_BITS means overflow
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + {{LENGTH_BITS{1'b0}}, ch[3:0]};
    assign acc_wide = {32'b0, acc_reg};
    assign code     = op_of(ch);
    assign is_digit = ch inside {[CH_ZERO:CH_NINE]};

    always_comb begin
        at_start_next    = at_start_reg;
        have_digits_next = have_digits_reg;
        acc_next         = acc_reg;
        ovf_next         = ovf_reg;
        err_next         = err_reg;
        op_valid         = 1'b0;
        st_valid         = 1'b0;
        st_val           = ST_OK;
        if (in_valid) begin
            if (record_empty) begin
                st_valid = 1'b1;
                if (at_start_reg) begin
                    st_val = ST_EMPTY;
                end else if (err_reg != ST_OK) begin
                    st_val = err_reg;
                end else if (have_digits_reg) begin
                    st_val = ST_BAD_FORMAT;
                end else begin
                    st_val = ST_OK;
                end
            end else begin
                if (err_reg == ST_OK) begin
                    if (at_start_reg && last_char && ch == CH_STAR) begin
                        err_next = ST_EMPTY;
                    end else if (is_digit) begin
                        have_digits_next = 1'b1;
                        if (!ovf_reg) begin
                            if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'b0) begin
                                ovf_next = 1'b1;
                            end else begin
                                acc_next = prod[LENGTH_BITS-1:0];
                            end
                        end
                    end else begin
                        // bad format outranks invalid op, which outranks overflow
                        if (!have_digits_reg) begin
                            err_next = ST_BAD_FORMAT;
                        end else if (code == OP_NONE) begin
                            err_next = ST_BAD_OP;
                        end else if (ovf_reg) begin
                            err_next = ST_OVERFLOW;
                        end else begin
                            op_valid = 1'b1;
                        end
                        have_digits_next = 1'b0;
                        acc_next         = '0;
                        ovf_next         = 1'b0;
                    end
                end
                at_start_next = 1'b0;
                if (last_char) begin
                    st_valid = 1'b1;
                    st_val   = err_next;
                    if (err_next == ST_OK && have_digits_next) begin
                        st_val = ST_BAD_FORMAT;
                    end
                end
            end
            // back to the idle record state after every record end
            if (st_valid) begin
                at_start_next    = 1'b1;
                have_digits_next = 1'b0;
                acc_next         = '0;
                ovf_next         = 1'b0;
                err_next         = ST_OK;
            end
        end
    end

    always_comb begin
        op_res.kind      = KIND_OP;
        op_res.op_code   = code;
        op_res.op_length = acc_wide[31:0];
        op_res.status    = ST_OK;
        op_res.eor       = 1'b0;
        st_res.kind      = KIND_STATUS;
        st_res.op_code   = OP_M;
        st_res.op_length = 32'b0;
        st_res.status    = st_val;
        st_res.eor       = 1'b1;
        push.count       = {1'b0, op_valid} + {1'b0, st_valid};
        push.first       = op_valid ? op_res : st_res;
        push.second      = st_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg    <= 1'b1;
            have_digits_reg <= 1'b0;
            acc_reg         <= '0;
            ovf_reg         <= 1'b0;
            err_reg         <= ST_OK;
        end else begin
            at_start_reg    <= at_start_next;
            have_digits_reg <= have_digits_next;
            acc_reg         <= acc_next;
            ovf_reg         <= ovf_next;
            err_reg         <= err_next;
        end
    end

endmodule

FILE: rtl/core/csp_result_queue.sv
// Small result queue: takes up to two results a cycle, delivers one.
// Depends on csp_pkg.
module csp_result_queue
    import csp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t               entry_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]   count_reg, count_next;
    logic [RQ_PTR_W-1:0]   wr_ptr_1;
    logic                  pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    // need space for the worst case of two results from one character
    assign room      = count_reg <= RQ_CNT_W'(RQ_DEPTH - 2);
    assign wr_ptr_1  = wr_ptr_reg + RQ_PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(pop);
        count_next  = count_reg + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/cigar_string_parser.sv
// Top level of the CIGAR string parser: stream ports, parse step, result queue.
// Depends on csp_pkg, csp_parser and csp_result_queue.
//
// The block takes one CIGAR character per transfer and accepts a new character
// every cycle while s_tready is high. Digits build an operation length; each
// valid letter (M I D N S H P = X) produces an operation result. The
// character that ends a record (tlast, or tuser for a record with no CIGAR)
// also produces a status result; when that character is a letter, the
// operation result comes first and the status follows it. Results wait in a
// four-entry queue; s_tready drops while fewer than two entries are free, and
// the sustained rate is one character per cycle while m_tready
// stays high. Operations of a failed record are still delivered; drop them
// when the status is nonzero. The first error of a record is held and the
// rest of its characters are ignored.
module cigar_string_parser
    import csp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] record_empty
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] op_code, [35:4] op_length, [38:36] status
    output logic        m_tuser,   // [0] result_kind
    output logic        m_tlast    // end_of_record
);

    push_t   push;
    result_t out_res;
    logic    room;
    logic    in_xfer;

    // accept a transfer only when the queue can hold both possible results
    assign s_tready = room;
    assign in_xfer  = s_tvalid && room;

    csp_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (in_xfer),
        .ch           (s_tdata),
        .record_empty (s_tuser),
        .last_char    (s_tlast),
        .push         (push)
    );

    csp_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // pack the result fields, lowest bit first, zero-filled to a byte
    assign m_tdata = {1'b0, out_res.status, out_res.op_length, out_res.op_code};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.eor;

endmodule
